FILE: hw/rtl/fhss_pkg.sv
// ----------------------------------------------------------------------------
// fhss_pkg: shared types and constants of the first-hit segment/sphere test.
// Holds the item structs, the fixed-point widths and the radius constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fhss_pkg;

	// Coordinate width; the datapath widths below follow from it and from T_FRAC.
	localparam int COORD_BITS = 24;
	// Differences of two coordinates.
	localparam int DIFF_W = COORD_BITS + 1;
	// Squared segment length (unsigned) and dot product (signed).
	localparam int LEN_W = 2 * COORD_BITS + 2;
	localparam int DOT_W = 2 * COORD_BITS + 3;
	// Projection parameter t: 16 fraction bits, range 0..1 inclusive.
	localparam int T_FRAC = 16;
	localparam int T_W = T_FRAC + 1;
	// Rounded per-axis offset of the closest point, Q.8.
	localparam int D_W = COORD_BITS + 3;
	// Shared multiplier operand and product widths.
	localparam int MUL_W = (D_W > T_W + 1) ? D_W : T_W + 1;
	localparam int PROD_W = 2 * MUL_W;
	// Squared distance, Q.16.
	localparam int DIST_W = 2 * D_W;

	// Item field widths.
	localparam int SIZE_W = 6;
	localparam int NUM_W = 8;

	// Radius in Q.8 is (RAD_BASE + RAD_STEP * size + RAD_BIAS) / RAD_DIV.
	localparam int RAD_BASE = 34560;
	localparam int RAD_STEP = 10752;
	localparam int RAD_BIAS = 50;
	localparam int RAD_DIV = 100;
	localparam int RAD_W = 13;
	localparam int R2_W = 2 * RAD_W;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// One target item.
	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t start_z;
		coord_t end_x;
		coord_t end_y;
		coord_t end_z;
		coord_t center_x;
		coord_t center_y;
		coord_t center_z;
		logic [SIZE_W-1:0] size_code;
		logic [NUM_W-1:0] target_number;
		logic list_end;
	} target_t;

	// One result item.
	typedef struct packed {
		logic any_hit;
		logic [NUM_W-1:0] hit_number;
	} result_t;

	// Status of the serial divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fhss_divider.sv
// ----------------------------------------------------------------------------
// fhss_divider: serial restoring divider for the projection parameter.
// Produces floor(dividend * 2^16 / divisor), one quotient bit per cycle,
// for a dividend known to lie below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module fhss_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [fhss_pkg::LEN_W-1:0]  dividend,
	input  wire logic [fhss_pkg::LEN_W-1:0]  divisor,
	output fhss_pkg::div_status_t            status,
	output logic      [fhss_pkg::T_FRAC-1:0] quotient
);

	localparam int CNT_W = $clog2(fhss_pkg::T_FRAC + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [fhss_pkg::LEN_W:0]    rem_q;
	logic [fhss_pkg::T_FRAC-1:0] quo_q;

	logic [fhss_pkg::LEN_W:0]    rem_sh;
	logic [fhss_pkg::LEN_W:0]    rem_sub;
	logic                        take;

	// One restoring step: shift the remainder and subtract where it fits.
	always_comb begin
		rem_sh  = {rem_q[fhss_pkg::LEN_W-1:0], 1'b0};
		take    = rem_sh >= {1'b0, divisor};
		rem_sub = rem_sh - {1'b0, divisor};
	end

	// Step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(fhss_pkg::T_FRAC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub : rem_sh;
			quo_q <= {quo_q[fhss_pkg::T_FRAC-2:0], take};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/first_hit_segment_sphere_test.sv
// Each item runs through the sequencer alone: a new item is taken only when
// the last has finished. An item with a zero-length segment or a clamped t
// skips the division. Throughput is set by the one shared multiplier
// (13 products in turn) and the 16-step serial divider.
// A result item appears in the cycle after the last item of a list finishes.
// Reset (arst_n low) clears the sequencer, the found state and result_valid.
// ----------------------------------------------------------------------------
// first_hit_segment_sphere_test: first-hit test of a shot segment against a
// list of spheres. Each item is tested by a sequencer around one multiplier,
// and the first hitting target is reported when the list ends.
// ----------------------------------------------------------------------------
`default_nettype none

module first_hit_segment_sphere_test #(
	parameter int MAX_TARGETS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              target_valid,
	output logic                   target_stall,
	input  wire fhss_pkg::target_t target,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output fhss_pkg::result_t      result
);

	localparam int LUT_SIZE = 2 ** fhss_pkg::SIZE_W;
	localparam int LUT_NUM  = 2 ** fhss_pkg::NUM_W;
	localparam logic [1:0] AXIS_LAST = 2'd2;
	localparam logic [fhss_pkg::T_W-1:0] T_ONE = fhss_pkg::T_W'(1) << fhss_pkg::T_FRAC;
	localparam logic [fhss_pkg::PROD_W-1:0] ROUND_HALF =
		fhss_pkg::PROD_W'(1) << (fhss_pkg::T_FRAC - 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_ACC  = 6'b000100,
		ST_TSEL = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	typedef enum logic [4:0] {
		PH_LEN = 5'b00001,
		PH_DOT = 5'b00010,
		PH_OFF = 5'b00100,
		PH_SQ  = 5'b01000,
		PH_RAD = 5'b10000
	} phase_t;

	// Sequencer and list state.
	state_t                     state_q;
	phase_t                     phase_q;
	logic [1:0]                 axis_q;
	logic                       result_valid_q;
	logic                       found_flag_q;
	logic [fhss_pkg::NUM_W-1:0] found_number_q;

	// Item datapath registers.
	logic signed [fhss_pkg::DIFF_W-1:0] ab_q [3];
	logic signed [fhss_pkg::DIFF_W-1:0] ap_q [3];
	logic        [fhss_pkg::RAD_W-1:0]  rq8_q;
	logic        [fhss_pkg::NUM_W-1:0]  num_q;
	logic                               last_q;
	logic signed [fhss_pkg::PROD_W-1:0] prod_q;
	logic        [fhss_pkg::LEN_W-1:0]  len2_q;
	logic signed [fhss_pkg::DOT_W-1:0]  dot_q;
	logic        [fhss_pkg::T_W-1:0]    t_q;
	logic signed [fhss_pkg::D_W-1:0]    d_q;
	logic        [fhss_pkg::DIST_W-1:0] dist_q;
	logic        [fhss_pkg::R2_W-1:0]   r2_q;
	fhss_pkg::result_t                  result_q;

	// Constant tables.
	logic [fhss_pkg::RAD_W-1:0] rad_lut [LUT_SIZE];
	logic [fhss_pkg::NUM_W-1:0] num_lut [LUT_NUM];

	// Combinational helpers.
	logic                               accept;
	logic signed [fhss_pkg::MUL_W-1:0]  mul_a;
	logic signed [fhss_pkg::MUL_W-1:0]  mul_b;
	logic signed [fhss_pkg::PROD_W-1:0] mul_p;
	logic signed [fhss_pkg::PROD_W-1:0] ap_sh;
	logic signed [fhss_pkg::PROD_W-1:0] off_r;
	logic                               t_zero;
	logic                               t_full;
	logic                               div_start;
	fhss_pkg::div_status_t              div_status;
	logic [fhss_pkg::T_FRAC-1:0]        div_quotient;
	logic                               hit;
	logic                               new_flag;
	logic [fhss_pkg::NUM_W-1:0]         new_number;
	logic                               done_blocked;
	logic                               done_go;

	// Radius per size code, Q.8, rounded half up.
	for (genvar g = 0; g < LUT_SIZE; g++) begin : g_rad
		localparam int RQ = (fhss_pkg::RAD_BASE + fhss_pkg::RAD_STEP * g +
			fhss_pkg::RAD_BIAS) / fhss_pkg::RAD_DIV;
		assign rad_lut[g] = fhss_pkg::RAD_W'(RQ);
	end

	// Target number folded into the list length.
	for (genvar g = 0; g < LUT_NUM; g++) begin : g_num
		localparam int NV = (g % MAX_TARGETS) % LUT_NUM;
		assign num_lut[g] = fhss_pkg::NUM_W'(NV);
	end

	assign accept       = target_valid && !target_stall;
	assign target_stall = (state_q != ST_IDLE);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (phase_q)
			PH_LEN: begin
				mul_a = fhss_pkg::MUL_W'(ab_q[axis_q]);
				mul_b = fhss_pkg::MUL_W'(ab_q[axis_q]);
			end
			PH_DOT: begin
				mul_a = fhss_pkg::MUL_W'(ab_q[axis_q]);
				mul_b = fhss_pkg::MUL_W'(ap_q[axis_q]);
			end
			PH_OFF: begin
				mul_a = fhss_pkg::MUL_W'(ab_q[axis_q]);
				mul_b = fhss_pkg::MUL_W'($signed({1'b0, t_q}));
			end
			PH_SQ: begin
				mul_a = fhss_pkg::MUL_W'(d_q);
				mul_b = fhss_pkg::MUL_W'(d_q);
			end
			PH_RAD: begin
				mul_a = fhss_pkg::MUL_W'($signed({1'b0, rq8_q}));
				mul_b = fhss_pkg::MUL_W'($signed({1'b0, rq8_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Offset of the closest point: ap * 2^16 - ab * t, rounded to Q.8.
	always_comb begin
		ap_sh = fhss_pkg::PROD_W'(ap_q[axis_q]) <<< fhss_pkg::T_FRAC;
		off_r = ap_sh - prod_q + $signed(ROUND_HALF);
	end

	// Clamping of t before any division is started.
	always_comb begin
		t_zero = (len2_q == '0) || dot_q[fhss_pkg::DOT_W-1] || (dot_q == '0);
		t_full = !t_zero && (dot_q[fhss_pkg::LEN_W-1:0] >= len2_q);
		div_start = (state_q == ST_TSEL) && !t_zero && !t_full;
	end

	fhss_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dot_q[fhss_pkg::LEN_W-1:0]),
		.divisor  (len2_q),
		.status   (div_status),
		.quotient (div_quotient)
	);

	// Hit decision and the updated first-hit state.
	always_comb begin
		hit = dist_q < {{(fhss_pkg::DIST_W - fhss_pkg::R2_W){1'b0}}, r2_q};
		new_flag = found_flag_q || hit;
		new_number = found_flag_q ? found_number_q : num_q;
		done_blocked = last_q && result_valid_q && result_stall;
		done_go = (state_q == ST_DONE) && !done_blocked;
	end

	// Sequencer, result handshake and first-hit state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= PH_LEN;
			axis_q         <= '0;
			result_valid_q <= 1'b0;
			found_flag_q   <= 1'b0;
			found_number_q <= '0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
						phase_q <= PH_LEN;
						axis_q  <= '0;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					case (phase_q)
						PH_LEN: begin
							state_q <= ST_MUL;
							if (axis_q == AXIS_LAST) begin
								phase_q <= PH_DOT;
								axis_q  <= '0;
							end else begin
								axis_q <= axis_q + 2'd1;
							end
						end
						PH_DOT: begin
							if (axis_q == AXIS_LAST) begin
								state_q <= ST_TSEL;
								phase_q <= PH_OFF;
								axis_q  <= '0;
							end else begin
								state_q <= ST_MUL;
								axis_q  <= axis_q + 2'd1;
							end
						end
						PH_OFF: begin
							state_q <= ST_MUL;
							phase_q <= PH_SQ;
						end
						PH_SQ: begin
							state_q <= ST_MUL;
							if (axis_q == AXIS_LAST) begin
								phase_q <= PH_RAD;
							end else begin
								phase_q <= PH_OFF;
								axis_q  <= axis_q + 2'd1;
							end
						end
						PH_RAD: begin
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_TSEL: begin
					state_q <= div_start ? ST_DIV : ST_MUL;
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							result_valid_q <= 1'b1;
							found_flag_q   <= 1'b0;
							found_number_q <= '0;
						end else begin
							found_flag_q   <= new_flag;
							found_number_q <= new_number;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the item in work.
	always_ff @(posedge clk) begin
		if (accept) begin
			ab_q[0] <= fhss_pkg::DIFF_W'(target.end_x) - fhss_pkg::DIFF_W'(target.start_x);
			ab_q[1] <= fhss_pkg::DIFF_W'(target.end_y) - fhss_pkg::DIFF_W'(target.start_y);
			ab_q[2] <= fhss_pkg::DIFF_W'(target.end_z) - fhss_pkg::DIFF_W'(target.start_z);
			ap_q[0] <= fhss_pkg::DIFF_W'(target.center_x) -
				fhss_pkg::DIFF_W'(target.start_x);
			ap_q[1] <= fhss_pkg::DIFF_W'(target.center_y) -
				fhss_pkg::DIFF_W'(target.start_y);
			ap_q[2] <= fhss_pkg::DIFF_W'(target.center_z) -
				fhss_pkg::DIFF_W'(target.start_z);
			rq8_q  <= rad_lut[target.size_code];
			num_q  <= num_lut[target.target_number];
			last_q <= target.list_end;
			len2_q <= '0;
			dot_q  <= '0;
			dist_q <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_ACC) begin
			case (phase_q)
				PH_LEN: len2_q <= len2_q + prod_q[fhss_pkg::LEN_W-1:0];
				PH_DOT: dot_q  <= dot_q + $signed(prod_q[fhss_pkg::DOT_W-1:0]);
				PH_OFF: d_q    <= off_r[fhss_pkg::T_FRAC +: fhss_pkg::D_W];
				PH_SQ:  dist_q <= dist_q + prod_q[fhss_pkg::DIST_W-1:0];
				PH_RAD: r2_q   <= prod_q[fhss_pkg::R2_W-1:0];
				default: begin
				end
			endcase
		end
		if (state_q == ST_TSEL && !div_start) begin
			t_q <= t_zero ? '0 : T_ONE;
		end
		if (state_q == ST_DIV && div_status.done) begin
			t_q <= {1'b0, div_quotient};
		end
		if (done_go && last_q) begin
			result_q.any_hit    <= new_flag;
			result_q.hit_number <= new_flag ? new_number : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// A result item only ever follows the end of the last item of a list.
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE && last_q))
		else $error("result item without a finished last item");

	// The projection parameter never exceeds one when offsets are formed.
	a_t_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && phase_q == PH_OFF) |-> (t_q <= T_ONE))
		else $error("projection parameter out of range");

	// A miss reports target number zero.
	a_miss_number: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.any_hit) |-> (result.hit_number == '0))
		else $error("miss reported with a non-zero target number");

	// The first-hit state is clear after a list has been reported.
	a_found_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(done_go && last_q) |=> (!found_flag_q && found_number_q == '0))
		else $error("first-hit state not cleared at the end of a list");

	// The divider is only started while idle and then runs.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_status.busy ##1 div_status.busy)
		else $error("divider start while busy or not taken");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of first_hit_segment_sphere_test.
// Drives lists of sphere targets through the valid/stall input channel. A
// scoreboard class predicts which target is hit first in each list and
// compares every result item with the oldest prediction. A directed list of
// corner cases comes first, then random lists under several idling phases,
// including a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint COORD_MAX = 64'sd8388607;
	localparam longint COORD_MIN = -64'sd8388608;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int DRAIN_CYCLES = 60;

	// Predicts the first hit of each list and holds the outstanding results.
	class hit_scoreboard;
		bit found_flag;
		logic [fhss_pkg::NUM_W-1:0] found_number;
		fhss_pkg::result_t expected_q[$];
		int errors;

		// Closest point of the segment to the centre, compared with the radius.
		function bit sphere_hit(fhss_pkg::target_t tg);
			longint s[3], e[3], c[3], ab[3], ap[3];
			longint len2, dot, tpar, rem, off, d, dist2, rq8;
			len2 = 0;
			dot = 0;
			tpar = 0;
			dist2 = 0;
			s[0] = $signed(tg.start_x);
			s[1] = $signed(tg.start_y);
			s[2] = $signed(tg.start_z);
			e[0] = $signed(tg.end_x);
			e[1] = $signed(tg.end_y);
			e[2] = $signed(tg.end_z);
			c[0] = $signed(tg.center_x);
			c[1] = $signed(tg.center_y);
			c[2] = $signed(tg.center_z);
			for (int i = 0; i < 3; i++) begin
				ab[i] = e[i] - s[i];
				ap[i] = c[i] - s[i];
				len2 += ab[i] * ab[i];
				dot += ab[i] * ap[i];
			end
			// Projection parameter, clamped to 0..1, by restoring division.
			if (len2 != 0 && dot > 0) begin
				if (dot >= len2) begin
					tpar = 65536;
				end else begin
					rem = dot;
					for (int i = 0; i < fhss_pkg::T_FRAC; i++) begin
						rem = rem <<< 1;
						tpar = tpar << 1;
						if (rem >= len2) begin
							rem -= len2;
							tpar |= 1;
						end
					end
				end
			end
			// Offsets rounded to Q.8, half-way cases towards plus infinity.
			for (int i = 0; i < 3; i++) begin
				off = ap[i] * 65536 - ab[i] * tpar;
				d = (off + 32768) >>> 16;
				dist2 += d * d;
			end
			rq8 = (fhss_pkg::RAD_BASE + fhss_pkg::RAD_STEP * longint'(tg.size_code) +
				fhss_pkg::RAD_BIAS) / fhss_pkg::RAD_DIV;
			return dist2 < rq8 * rq8;
		endfunction

		// Called for every accepted target item.
		function void note_target(fhss_pkg::target_t tg);
			fhss_pkg::result_t res;
			if (sphere_hit(tg) && !found_flag) begin
				found_flag = 1'b1;
				found_number = tg.target_number;
			end
			if (tg.list_end) begin
				res.any_hit = found_flag;
				res.hit_number = found_flag ? found_number : '0;
				expected_q.push_back(res);
				found_flag = 1'b0;
				found_number = '0;
			end
		endfunction

		// Called for every accepted result item.
		function void check_result(fhss_pkg::result_t res);
			fhss_pkg::result_t exp_res;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: any_hit %0b hit_number %0d",
					$time, res.any_hit, res.hit_number);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (res.any_hit !== exp_res.any_hit) begin
				$display("%0t: any_hit expected %0b, actual %0b",
					$time, exp_res.any_hit, res.any_hit);
				errors++;
			end
			if (res.hit_number !== exp_res.hit_number) begin
				$display("%0t: hit_number expected %0d, actual %0d",
					$time, exp_res.hit_number, res.hit_number);
				errors++;
			end
		endfunction

		function int waiting();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic target_valid = 1'b0;
	logic target_stall;
	fhss_pkg::target_t target = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	fhss_pkg::result_t result;

	hit_scoreboard sb = new();

	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_off_req = 1'b0;
	int cycle_count = 0;

	first_hit_segment_sphere_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.target_valid(target_valid),
		.target_stall(target_stall),
		.target(target),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Clock generation.
	initial begin
		forever #4 clk = ~clk;
	end

	// Signed random value of the given number of bits.
	function automatic longint rand_span(int bits);
		return longint'($urandom_range((1 << bits) - 1)) - (longint'(1) << (bits - 1));
	endfunction

	function automatic fhss_pkg::target_t mk_target(longint sx, longint sy, longint sz,
			longint ex, longint ey, longint ez, longint cx, longint cy, longint cz,
			int size, int num, bit closes_list);
		fhss_pkg::target_t tg;
		tg.start_x = fhss_pkg::coord_t'(sx);
		tg.start_y = fhss_pkg::coord_t'(sy);
		tg.start_z = fhss_pkg::coord_t'(sz);
		tg.end_x = fhss_pkg::coord_t'(ex);
		tg.end_y = fhss_pkg::coord_t'(ey);
		tg.end_z = fhss_pkg::coord_t'(ez);
		tg.center_x = fhss_pkg::coord_t'(cx);
		tg.center_y = fhss_pkg::coord_t'(cy);
		tg.center_z = fhss_pkg::coord_t'(cz);
		tg.size_code = size[fhss_pkg::SIZE_W-1:0];
		tg.target_number = num[fhss_pkg::NUM_W-1:0];
		tg.list_end = closes_list;
		return tg;
	endfunction

	// Random target: mostly a centre placed near the segment so that hits and
	// near misses are frequent, sometimes every field fully random.
	function automatic fhss_pkg::target_t make_target(bit closes_list);
		longint sx, sy, sz, dx, dy, dz, k;
		int base_bits, seg_bits, off_bits;
		if ($urandom_range(15) == 0) begin
			return mk_target(rand_span(24), rand_span(24), rand_span(24),
				rand_span(24), rand_span(24), rand_span(24),
				rand_span(24), rand_span(24), rand_span(24),
				$urandom_range(63), $urandom_range(255), closes_list);
		end
		case ($urandom_range(3))
			0: base_bits = 10;
			1: base_bits = 16;
			2: base_bits = 22;
			default: base_bits = 24;
		endcase
		case ($urandom_range(5))
			0: seg_bits = 4;
			1: seg_bits = 8;
			2: seg_bits = 12;
			3: seg_bits = 16;
			4: seg_bits = 20;
			default: seg_bits = 24;
		endcase
		case ($urandom_range(4))
			0: off_bits = 8;
			1: off_bits = 11;
			2: off_bits = 12;
			3: off_bits = 13;
			default: off_bits = 14;
		endcase
		sx = rand_span(base_bits);
		sy = rand_span(base_bits);
		sz = rand_span(base_bits);
		// A zero-length segment now and then.
		if ($urandom_range(7) == 0) begin
			dx = 0;
			dy = 0;
			dz = 0;
		end else begin
			dx = rand_span(seg_bits);
			dy = rand_span(seg_bits);
			dz = rand_span(seg_bits);
		end
		// Centre projected between half a segment before and after the ends.
		k = longint'($urandom_range(32)) - 8;
		return mk_target(sx, sy, sz, sx + dx, sy + dy, sz + dz,
			sx + dx * k / 16 + rand_span(off_bits),
			sy + dy * k / 16 + rand_span(off_bits),
			sz + dz * k / 16 + rand_span(off_bits),
			$urandom_range(63), $urandom_range(255), closes_list);
	endfunction

	// Offers one target item, with random idle cycles before it.
	task automatic send_target(input fhss_pkg::target_t tg);
		while ($urandom_range(99) < idle_pct) begin
			target_valid <= 1'b0;
			@(posedge clk);
		end
		target <= tg;
		target_valid <= 1'b1;
		do @(posedge clk); while (target_stall);
		sb.note_target(tg);
	endtask

	// Corner cases: zero-length segments, clamped and divided t, first-hit
	// order, radius boundaries at both size extremes and extreme coordinates.
	task automatic run_directed();
		// Zero-length segment with the centre on the start point, then far off.
		send_target(mk_target(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5, 1'b1));
		send_target(mk_target(0, 0, 0, 0, 0, 0, 5000, 0, 0, 0, 6, 1'b1));
		// t clamped to 0, then a later hit with t clamped to 1 which is ignored,
		// then a divided t hit, also ignored.
		send_target(mk_target(0, 0, 0, 2560, 0, 0, -256, 0, 0, 0, 17, 1'b0));
		send_target(mk_target(0, 0, 0, 2560, 0, 0, 2860, 0, 0, 0, 3, 1'b0));
		send_target(mk_target(0, 0, 0, 768, 512, 256, 300, 200, 600, 63, 255, 1'b1));
		// A miss followed by a hit.
		send_target(mk_target(0, 0, 0, 100, 0, 0, 0, 90000, 0, 63, 0, 1'b0));
		send_target(mk_target(0, 0, 0, 100, 0, 0, 50, 100, 0, 0, 200, 1'b1));
		// A hit on target number zero.
		send_target(mk_target(10, 20, 30, 10, 20, 30, 10, 20, 30, 1, 0, 1'b1));
		// Extreme coordinates.
		send_target(mk_target(COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 63, 255, 1'b1));
		send_target(mk_target(COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MAX, COORD_MAX, COORD_MAX, 63, 255, 1'b1));
		send_target(mk_target(COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MIN, 0, 128, 1'b1));
		send_target(mk_target(COORD_MIN, 0, COORD_MAX, COORD_MAX, 0, COORD_MIN,
			-1, 0, 0, 0, 85, 1'b1));
		// Distance exactly on the radius misses, one step inside hits.
		send_target(mk_target(0, 0, 0, 0, 0, 0, 346, 0, 0, 0, 11, 1'b1));
		send_target(mk_target(0, 0, 0, 0, 0, 0, 345, 0, 0, 0, 12, 1'b1));
		send_target(mk_target(0, 0, 0, 0, 0, 0, 0, -7119, 0, 63, 13, 1'b1));
		send_target(mk_target(0, 0, 0, 0, 0, 0, 0, 0, -7118, 63, 14, 1'b1));
		// Short segment where the rounding of the offset matters.
		send_target(mk_target(0, 0, 0, 3, 0, 0, 1, 345, 0, 0, 170, 1'b1));
	endtask

	// Random lists until at least n items have been offered.
	task automatic run_lists(input int n, input int max_len);
		int sent, len;
		sent = 0;
		while (sent < n) begin
			if (max_len > 5 && $urandom_range(7) == 0)
				len = $urandom_range(max_len, 6);
			else
				len = $urandom_range(max_len < 5 ? max_len : 5, 1);
			for (int i = 0; i < len; i++) begin
				send_target(make_target(i == len - 1));
				sent++;
			end
		end
	endtask

	// Result side: checks accepted items and drives the stall pattern.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				sb.check_result(result);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Reset, stimulus phases and end of run.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_lists(145, 20);

		idle_pct = 63;
		run_lists(145, 20);

		idle_pct = 0;
		stall_pct = 63;
		run_lists(145, 20);

		idle_pct = 8;
		stall_pct = 8;
		run_lists(145, 20);

		// Receiver holds off while short lists keep arriving.
		idle_pct = 0;
		stall_pct = 0;
		hold_off_req = 1'b1;
		run_lists(100, 2);

		target_valid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
